>>> rtl/bdpc_pkg.sv
package bdpc_pkg;

   // request codes
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // event kinds on the result channel
   localparam logic [2:0] EV_QUERY   = 3'd0;
   localparam logic [2:0] EV_PRESSED = 3'd1;
   localparam logic [2:0] EV_SHORT   = 3'd2;
   localparam logic [2:0] EV_LONG    = 3'd3;
   localparam logic [2:0] EV_VLONG   = 3'd4;

   // sticky flag positions; release kinds share their numbers with their flags
   localparam logic [2:0] FLAG_PRESSED  = 3'd0;
   localparam logic [2:0] FLAG_RELEASED = 3'd1;
   localparam logic [2:0] FLAG_VLONG    = 3'd4;
   localparam int         FLAG_W        = 5;

   // register indexes
   localparam logic [2:0] CSR_BUTTON_COUNT  = 3'd0;
   localparam logic [2:0] CSR_INVERT_MASK   = 3'd1;
   localparam logic [2:0] CSR_FUNCTIONS     = 3'd2;
   localparam logic [2:0] CSR_DEBOUNCE      = 3'd3;
   localparam logic [2:0] CSR_LONG          = 3'd4;
   localparam logic [2:0] CSR_VERY_LONG     = 3'd5;
   localparam logic [2:0] CSR_FAST_WINDOW   = 3'd6;
   localparam logic [2:0] CSR_FAST_COUNT    = 3'd7;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int RC_W       = 11;

   typedef struct packed {
      logic [3:0]  button_count;
      logic [7:0]  invert_mask;
      logic [23:0] button_functions;
      logic [9:0]  debounce_ms;
      logic [13:0] long_ms;
      logic [13:0] very_long_ms;
      logic [13:0] fast_window_ms;
      logic [4:0]  fast_press_count;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic tick;
      logic emit;
      logic skip;
      logic query;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_query;
      logic accept_changes;
      logic cur_changed;
      logic cur_last;
      logic out_free;
   } dp_sts_type;

   function automatic logic [2:0] func_code(input logic [23:0] funcs, input logic [2:0] idx);
      logic [4:0] base;
      base = 5'(idx) * 5'd3;
      return funcs[base +: 3];
   endfunction

endpackage

>>> rtl/bdpc_channels.sv
interface bdpc_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] raw_levels;
   logic [2:0] query_button;
   logic [2:0] query_kind;

   modport source (output valid, req_type, raw_levels, query_button, query_kind,
                   input ready);
   modport sink (input valid, req_type, raw_levels, query_button, query_kind,
                 output ready);
endinterface

interface bdpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] button_index;
   logic [2:0] event_kind;
   logic [2:0] fired_function;
   logic       flag_was_set;
   logic       last_of_run;

   modport source (output valid, button_index, event_kind, fired_function, flag_was_set,
                   last_of_run, input ready);
   modport sink (input valid, button_index, event_kind, fired_function, flag_was_set,
                 last_of_run, output ready);
endinterface

>>> rtl/bdpc_csr.sv
module bdpc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bdpc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bdpc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output bdpc_pkg::cfg_type                   cfg
);
   import bdpc_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.button_count     <= 4'd0;
         cfg_ff.invert_mask      <= 8'd0;
         cfg_ff.button_functions <= 24'd0;
         cfg_ff.debounce_ms      <= 10'd100;
         cfg_ff.long_ms          <= 14'd1000;
         cfg_ff.very_long_ms     <= 14'd10000;
         cfg_ff.fast_window_ms   <= 14'd1000;
         cfg_ff.fast_press_count <= 5'd10;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BUTTON_COUNT: cfg_ff.button_count     <= csr_wdata[3:0];
            CSR_INVERT_MASK:  cfg_ff.invert_mask      <= csr_wdata[7:0];
            CSR_FUNCTIONS:    cfg_ff.button_functions <= csr_wdata[23:0];
            CSR_DEBOUNCE:     cfg_ff.debounce_ms      <= csr_wdata[9:0];
            CSR_LONG:         cfg_ff.long_ms          <= csr_wdata[13:0];
            CSR_VERY_LONG:    cfg_ff.very_long_ms     <= csr_wdata[13:0];
            CSR_FAST_WINDOW:  cfg_ff.fast_window_ms   <= csr_wdata[13:0];
            CSR_FAST_COUNT:   cfg_ff.fast_press_count <= csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/bdpc_ctrl.sv
module bdpc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bdpc_pkg::dp_sts_type  sts,
   output bdpc_pkg::dp_cmd_type  cmd
);
   import bdpc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.is_query) begin
               if (sts.out_free) begin
                  cmd.query = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else begin
               cmd.tick = 1'b1;
               state_in = sts.accept_changes ? ST_SCAN : ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (sts.cur_changed) begin
               if (sts.out_free) begin
                  cmd.emit = 1'b1;
                  if (sts.cur_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               cmd.skip = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/bdpc_dp.sv
module bdpc_dp #(
   parameter int NUM_BUTTONS   = 8,
   parameter int AGE_BITS      = 14,
   parameter int LOCKOUT_VALUE = 1000
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bdpc_pkg::cfg_type     cfg,
   input  bdpc_pkg::dp_cmd_type  cmd,
   output bdpc_pkg::dp_sts_type  sts,
   input  logic                  req_type,
   input  logic [7:0]            raw_levels,
   input  logic [2:0]            query_button,
   input  logic [2:0]            query_kind,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            button_index,
   output logic [2:0]            event_kind,
   output logic [2:0]            fired_function,
   output logic                  flag_was_set,
   output logic                  last_of_run
);
   import bdpc_pkg::*;

   localparam int SEL_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int CMP_W = (AGE_BITS > 14) ? AGE_BITS : 14;
   localparam int PAD_W = (NUM_BUTTONS > 8) ? NUM_BUTTONS : 8;
   localparam int LIM   = (NUM_BUTTONS < 8) ? NUM_BUTTONS : 8;
   localparam logic signed [RC_W-1:0] LOCK_NEG = -(RC_W'(LOCKOUT_VALUE));

   // captured request
   logic             type_ff;
   logic [7:0]       raw_ff;
   logic [2:0]       qbtn_ff;
   logic [2:0]       qkind_ff;

   // debounce state
   logic [7:0]       cand_ff;
   logic [9:0]       stable_ff;
   logic             pending_ff;

   // scan state
   logic [SEL_W-1:0]       sel_ff;
   logic [NUM_BUTTONS-1:0] mask_ff;

   // per-button state
   logic [NUM_BUTTONS-1:0]  pressed_ff;
   logic [AGE_BITS-1:0]     hold_ff   [NUM_BUTTONS];
   logic [AGE_BITS-1:0]     since_ff  [NUM_BUTTONS];
   logic signed [RC_W-1:0]  repeat_ff [NUM_BUTTONS];
   logic [FLAG_W-1:0]       sticky_ff [NUM_BUTTONS];

   // result register
   logic             out_valid_ff;
   logic [2:0]       out_idx_ff;
   logic [2:0]       out_kind_ff;
   logic [2:0]       out_fn_ff;
   logic             out_flag_ff;
   logic             out_last_ff;

   logic [3:0]       n_act;
   logic [7:0]       act_mask;
   logic [7:0]       vec;
   logic [PAD_W-1:0] pressed_pad;
   logic [PAD_W-1:0] cand_pad;
   logic [PAD_W-1:0] chg_pad;
   logic [7:0]       chg8;
   logic             same;
   logic             take;
   logic [2:0]       sel3;
   logic             cur_p;
   logic [NUM_BUTTONS-1:0] rest;
   logic             fast;
   logic signed [RC_W-1:0] rc_inc;
   logic             fire;
   logic signed [RC_W-1:0] rc_next;
   logic [2:0]       fn;
   logic [2:0]       rel_kind;
   logic [FLAG_W-1:0] rel_flags;
   logic             qvalid;
   logic             q_flag;
   logic             out_free;

   always_comb begin
      n_act = (cfg.button_count > 4'(LIM)) ? 4'(LIM) : cfg.button_count;
      for (int i = 0; i < 8; i++) begin
         act_mask[i] = (4'(i) < n_act);
      end
   end

   // pressed vector: low level is pressed unless the inversion bit is set
   assign vec         = (~raw_ff ^ cfg.invert_mask) & act_mask;
   assign pressed_pad = PAD_W'(pressed_ff);
   assign cand_pad    = PAD_W'(cand_ff);
   assign chg8        = (cand_ff ^ pressed_pad[7:0]) & act_mask;
   assign chg_pad     = PAD_W'(chg8);
   assign same        = (vec == cand_ff);
   assign take        = same && pending_ff && (stable_ff >= cfg.debounce_ms);

   assign sel3  = 3'(sel_ff);
   assign cur_p = cand_pad[sel_ff];

   always_comb begin
      rest         = mask_ff;
      rest[sel_ff] = 1'b0;
   end

   // press path: fast repeat counting
   assign fast    = CMP_W'(since_ff[sel_ff]) < CMP_W'(cfg.fast_window_ms);
   assign rc_inc  = repeat_ff[sel_ff] + RC_W'(1);
   assign fire    = fast && (rc_inc >= $signed(RC_W'(cfg.fast_press_count)));
   assign rc_next = !fast ? RC_W'(1) : (fire ? LOCK_NEG : rc_inc);
   assign fn      = fire ? func_code(cfg.button_functions, sel3) : 3'd0;

   // release path: class by hold time
   always_comb begin
      if (CMP_W'(hold_ff[sel_ff]) < CMP_W'(cfg.long_ms)) begin
         rel_kind = EV_SHORT;
      end else if (CMP_W'(hold_ff[sel_ff]) < CMP_W'(cfg.very_long_ms)) begin
         rel_kind = EV_LONG;
      end else begin
         rel_kind = EV_VLONG;
      end
      rel_flags = (sticky_ff[sel_ff] & ~(FLAG_W'(1) << FLAG_PRESSED))
                | (FLAG_W'(1) << FLAG_RELEASED) | (FLAG_W'(1) << rel_kind);
   end

   // query path
   assign qvalid = ({1'b0, qbtn_ff} < n_act) && (qkind_ff <= FLAG_VLONG);
   assign q_flag = qvalid ? sticky_ff[sel_ff][qkind_ff] : 1'b0;

   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         raw_ff   <= raw_levels;
         qbtn_ff  <= query_button;
         qkind_ff <= query_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff    <= 8'hFF;
         stable_ff  <= '0;
         pending_ff <= 1'b0;
      end else if (cmd.tick) begin
         if (!same) begin
            cand_ff    <= vec;
            stable_ff  <= '0;
            pending_ff <= 1'b1;
         end else if (take) begin
            pending_ff <= 1'b0;
         end else if (~&stable_ff) begin
            stable_ff <= stable_ff + 10'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff  <= '0;
         mask_ff <= '0;
      end else if (cmd.capture) begin
         sel_ff <= SEL_W'(query_button);
      end else if (cmd.tick) begin
         sel_ff  <= '0;
         mask_ff <= take ? chg_pad[NUM_BUTTONS-1:0] : '0;
      end else if (cmd.emit || cmd.skip) begin
         sel_ff  <= sel_ff + SEL_W'(1);
         mask_ff <= rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff <= '0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            hold_ff[i]   <= '0;
            since_ff[i]  <= '0;
            repeat_ff[i] <= '0;
            sticky_ff[i] <= '0;
         end
      end else if (cmd.tick) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (~&hold_ff[i]) begin
               hold_ff[i] <= hold_ff[i] + AGE_BITS'(1);
            end
            if (~&since_ff[i]) begin
               since_ff[i] <= since_ff[i] + AGE_BITS'(1);
            end
         end
      end else if (cmd.emit) begin
         pressed_ff[sel_ff] <= cur_p;
         hold_ff[sel_ff]    <= '0;
         if (cur_p) begin
            since_ff[sel_ff]  <= '0;
            repeat_ff[sel_ff] <= rc_next;
            sticky_ff[sel_ff] <= FLAG_W'(1) << FLAG_PRESSED;
         end else begin
            sticky_ff[sel_ff] <= rel_flags;
         end
      end else if (cmd.query && qvalid) begin
         sticky_ff[sel_ff] <= sticky_ff[sel_ff] & ~(FLAG_W'(1) << qkind_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.query) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_idx_ff  <= sel3;
         out_kind_ff <= cur_p ? EV_PRESSED : rel_kind;
         out_fn_ff   <= cur_p ? fn : 3'd0;
         out_flag_ff <= 1'b0;
         out_last_ff <= (rest == '0);
      end else if (cmd.query) begin
         out_idx_ff  <= qbtn_ff;
         out_kind_ff <= EV_QUERY;
         out_fn_ff   <= 3'd0;
         out_flag_ff <= q_flag;
         out_last_ff <= 1'b1;
      end
   end

   assign sts.is_query       = (type_ff == REQ_QUERY);
   assign sts.accept_changes = take && (chg8 != 8'd0);
   assign sts.cur_changed    = mask_ff[sel_ff];
   assign sts.cur_last       = (rest == '0);
   assign sts.out_free       = out_free;

   assign rsp_valid      = out_valid_ff;
   assign button_index   = out_idx_ff;
   assign event_kind     = out_kind_ff;
   assign fired_function = out_fn_ff;
   assign flag_was_set   = out_flag_ff;
   assign last_of_run    = out_last_ff;

endmodule

>>> rtl/button_debounce_press_classifier.sv
// channel   dir  handshake       beat contents
// req_ch    in   valid / ready   req_type, raw_levels, query_button, query_kind
// rsp_ch    out  valid / ready   button_index, event_kind, fired_function,
//                                flag_was_set, last_of_run
// csr_*     in   csr_we only     csr_index, csr_wdata (no read-back)
//
// one request at a time: an accept step, then an execute step
// a tick with no accepted change ends after its execute step; a query ends once its result is registered
// an accepted change adds a scan step for each button index up to the highest
// changed button
// a full result register blocks a query's execute step or a scan emit until rsp_ch drains
// reset is synchronous and active high; it restores register defaults and all
// per-button state
module button_debounce_press_classifier #(
   parameter int NUM_BUTTONS   = 8,
   parameter int AGE_BITS      = 14,
   parameter int LOCKOUT_VALUE = 1000
) (
   input  logic                              clock,
   input  logic                              reset,
   bdpc_req_if.sink                          req_ch,
   bdpc_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [bdpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bdpc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bdpc_pkg::*;

   cfg_type    cfg;
   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       req_ready;
   logic       rsp_valid;
   logic [2:0] button_index;
   logic [2:0] event_kind;
   logic [2:0] fired_function;
   logic       flag_was_set;
   logic       last_of_run;

   // register file; the user must write it only while idle, the block does not enforce this
   bdpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: idle, execute (tick or query), scan over buttons
   bdpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // debounce, per-button ages and flags, result register
   bdpc_dp #(
      .NUM_BUTTONS   (NUM_BUTTONS),
      .AGE_BITS      (AGE_BITS),
      .LOCKOUT_VALUE (LOCKOUT_VALUE)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .sts            (sts),
      .req_type       (req_ch.req_type),
      .raw_levels     (req_ch.raw_levels),
      .query_button   (req_ch.query_button),
      .query_kind     (req_ch.query_kind),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ch.ready),
      .button_index   (button_index),
      .event_kind     (event_kind),
      .fired_function (fired_function),
      .flag_was_set   (flag_was_set),
      .last_of_run    (last_of_run)
   );

   // channel hookup
   assign req_ch.ready          = req_ready;
   assign rsp_ch.valid          = rsp_valid;
   assign rsp_ch.button_index   = button_index;
   assign rsp_ch.event_kind     = event_kind;
   assign rsp_ch.fired_function = fired_function;
   assign rsp_ch.flag_was_set   = flag_was_set;
   assign rsp_ch.last_of_run    = last_of_run;

endmodule
